// File: hdl/serial_frame_deframer_crc_check_macros.svh
// assertion macros for the serial frame deframer
`ifndef SERIAL_FRAME_DEFRAMER_CRC_CHECK_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_CRC_CHECK_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfd assertion failed");

// antecedent implies consequent in the next cycle
`define SFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfd assertion failed");

`else

`define SFD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SFD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

    // framing constants
    localparam int BYTE_W            = 8;
    localparam int HDR_LEN           = 6;

    // crc-16/modbus, reflected
    localparam int           CRC_BITS          = 8;
    localparam int           CRC_BITS_PER_STEP = 2;
    localparam logic [15:0]  CRC_POLY          = 16'hA001;
    localparam logic [15:0]  CRC_INIT          = 16'hFFFF;

    // result status codes
    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_FORMAT  = 2'd1,
        ST_NO_END  = 2'd2,
        ST_CRC_BAD = 2'd3
    } status_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_ONE = 2'd0,
        CFG_START_TWO = 2'd1,
        CFG_VERSION   = 2'd2,
        CFG_END       = 2'd3
    } cfg_index_t;

    // command bundle from the sequencer to the crc unit
    typedef struct packed {
        logic              init;
        logic              start;
        logic [BYTE_W-1:0] data;
    } crc_cmd_t;

endpackage

// File: hdl/sfd_ifs.sv
`timescale 1ns / 1ps

// received byte channel
interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface sfd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  msg_type;
    logic [15:0] seq_number;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        last;

    modport source (
        output valid, output status, output msg_type, output seq_number,
        output payload_length, output data_byte, output data_valid, output last,
        input ready
    );
    modport sink (
        input valid, input status, input msg_type, input seq_number,
        input payload_length, input data_byte, input data_valid, input last,
        output ready
    );
endinterface

// File: hdl/sfd_ram.sv
`timescale 1ns / 1ps

module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sfd_crc_unit.sv
`timescale 1ns / 1ps

module sfd_crc_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  sfd_pkg::crc_cmd_t cmd,
    output logic              busy,
    output logic [15:0]       crc
);

    localparam int STEPS = sfd_pkg::CRC_BITS / sfd_pkg::CRC_BITS_PER_STEP;
    localparam int CNT_W = (STEPS > 2) ? $clog2(STEPS) : 1;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      src;
    logic [15:0]      stepped;

    // shared shift unit: advances the crc by CRC_BITS_PER_STEP reflected bit steps
    always_comb
    begin
        src = cmd.start ? (crc_reg ^ {8'h00, cmd.data}) : crc_reg;
        stepped = src;
        for (int i = 0; i < sfd_pkg::CRC_BITS_PER_STEP; i++)
        begin
            stepped = stepped[0] ? ((stepped >> 1) ^ sfd_pkg::CRC_POLY) : (stepped >> 1);
        end
    end

    // step counter
    always_comb
    begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (cmd.init)
        begin
            crc_next = sfd_pkg::CRC_INIT;
        end
        else if (cmd.start)
        begin
            crc_next = stepped;
            cnt_next = CNT_W'(STEPS - 1);
        end
        else if (cnt_reg != '0)
        begin
            crc_next = stepped;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= sfd_pkg::CRC_INIT;
            cnt_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign crc  = crc_reg;

endmodule

// File: hdl/serial_frame_deframer_crc_check.sv
// a header or payload byte gets its first crc step in the accept cycle, then 3 more steps
// of the shared crc unit at 2 bits per step, then S_CRC ends; marker and crc bytes skip it
// the end byte and a header with a format error hold the input until their results are
// loaded: a single result after the byte's own work, a good frame's payload bytes each read
// from the ram in S_RD and then loaded in S_EMIT, waiting while res.ready stays low
// reset: rst_n is asynchronous, active low; resets sequencer, counters and config registers
`timescale 1ns / 1ps

`include "serial_frame_deframer_crc_check_macros.svh"

module serial_frame_deframer_crc_check #(
    parameter int PAYLOAD_DEPTH = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    sfd_byte_if.sink     rx,
    sfd_result_if.source res
);

    localparam int          AW       = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int          CW       = $clog2(PAYLOAD_DEPTH + 1);
    localparam logic [15:0] DEPTH_16 = 16'(PAYLOAD_DEPTH);
    localparam logic [2:0]  HDR_LAST = 3'(sfd_pkg::HDR_LEN);

    typedef enum logic [2:0] {
        PH_SOF1,
        PH_SOF2,
        PH_HDR,
        PH_PAY,
        PH_CRCL,
        PH_CRCH,
        PH_END
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_ONE,
        S_RD,
        S_EMIT
    } state_t;

    // configuration registers
    logic [7:0] start_one_reg, start_two_reg, version_reg, end_reg;

    // sequencer state
    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [2:0]       hdr_cnt_reg, hdr_cnt_next;
    logic [CW-1:0]    pay_cnt_reg, pay_cnt_next;
    logic [CW-1:0]    emit_idx_reg, emit_idx_next;
    logic [15:0]      rcrc_reg, rcrc_next;
    sfd_pkg::status_t status_reg, status_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [7:0]  out_type_reg, out_type_next;
    logic [15:0] out_seq_reg, out_seq_next;
    logic [15:0] out_len_reg, out_len_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_dv_reg, out_dv_next;
    logic        out_last_reg, out_last_next;

    // header store
    logic [7:0] hdr_store [sfd_pkg::HDR_LEN];
    logic       hdr_we;

    logic              accept;
    logic              out_free;
    logic [7:0]        b;
    logic [15:0]       hdr_len_w;
    logic [15:0]       hdr_seq_w;
    logic [CW-1:0]     pay_cnt_inc;
    logic [CW-1:0]     emit_inc;
    sfd_pkg::crc_cmd_t crc_cmd;
    logic              crc_busy;
    logic [15:0]       crc_val;
    logic              ram_we, ram_re;
    logic [7:0]        ram_rdata;

    sfd_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (crc_cmd),
        .busy  (crc_busy),
        .crc   (crc_val)
    );

    sfd_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH),
        .AW    (AW)
    ) u_pay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pay_cnt_reg[AW-1:0]),
        .wdata (b),
        .re    (ram_re),
        .raddr (emit_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign b           = rx.rx_byte;
    assign rx.ready    = (state_reg == S_IDLE);
    assign accept      = rx.valid && rx.ready;
    assign out_free    = !out_valid_reg || res.ready;
    assign hdr_seq_w   = {hdr_store[3], hdr_store[2]};
    assign hdr_len_w   = {hdr_store[5], hdr_store[4]};
    assign pay_cnt_inc = pay_cnt_reg + 1'b1;
    assign emit_inc    = emit_idx_reg + 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_one_reg <= 8'hAA;
            start_two_reg <= 8'h55;
            version_reg   <= 8'h01;
            end_reg       <= 8'h0D;
        end
        else if (cfg_wr_en)
        begin
            case (sfd_pkg::cfg_index_t'(cfg_index))
                sfd_pkg::CFG_START_ONE: start_one_reg <= cfg_data;
                sfd_pkg::CFG_START_TWO: start_two_reg <= cfg_data;
                sfd_pkg::CFG_VERSION:   version_reg   <= cfg_data;
                sfd_pkg::CFG_END:       end_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // header byte capture
    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_store[hdr_cnt_reg] <= b;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        pay_cnt_next    = pay_cnt_reg;
        emit_idx_next   = emit_idx_reg;
        rcrc_next       = rcrc_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_type_next   = out_type_reg;
        out_seq_next    = out_seq_reg;
        out_len_next    = out_len_reg;
        out_data_next   = out_data_reg;
        out_dv_next     = out_dv_reg;
        out_last_next   = out_last_reg;
        crc_cmd         = '0;
        crc_cmd.data    = b;
        hdr_we          = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        // beat taken downstream
        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (phase_reg)
                        PH_SOF1:
                        begin
                            if (b == start_one_reg)
                            begin
                                phase_next = PH_SOF2;
                            end
                        end
                        PH_SOF2:
                        begin
                            hdr_cnt_next = '0;
                            if (b == start_two_reg)
                            begin
                                phase_next   = PH_HDR;
                                crc_cmd.init = 1'b1;
                            end
                            else if (b == start_one_reg)
                            begin
                                phase_next = PH_SOF2;
                            end
                            else
                            begin
                                phase_next = PH_SOF1;
                            end
                        end
                        PH_HDR:
                        begin
                            hdr_we        = 1'b1;
                            hdr_cnt_next  = hdr_cnt_reg + 1'b1;
                            crc_cmd.start = 1'b1;
                            state_next    = S_CRC;
                        end
                        PH_PAY:
                        begin
                            ram_we        = 1'b1;
                            pay_cnt_next  = pay_cnt_inc;
                            crc_cmd.start = 1'b1;
                            state_next    = S_CRC;
                            if (16'(pay_cnt_inc) >= hdr_len_w)
                            begin
                                phase_next = PH_CRCL;
                            end
                        end
                        PH_CRCL:
                        begin
                            rcrc_next  = {8'h00, b};
                            phase_next = PH_CRCH;
                        end
                        PH_CRCH:
                        begin
                            rcrc_next  = {b, rcrc_reg[7:0]};
                            phase_next = PH_END;
                        end
                        PH_END:
                        begin
                            phase_next   = PH_SOF1;
                            hdr_cnt_next = '0;
                            pay_cnt_next = '0;
                            rcrc_next    = '0;
                            if (b != end_reg)
                            begin
                                status_next = sfd_pkg::ST_NO_END;
                                state_next  = S_ONE;
                            end
                            else if (crc_val != rcrc_reg)
                            begin
                                status_next = sfd_pkg::ST_CRC_BAD;
                                state_next  = S_ONE;
                            end
                            else if (hdr_len_w == '0)
                            begin
                                status_next = sfd_pkg::ST_GOOD;
                                state_next  = S_ONE;
                            end
                            else
                            begin
                                emit_idx_next = '0;
                                state_next    = S_RD;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_SOF1;
                        end
                    endcase
                end
            end
            S_CRC:
            begin
                if (!crc_busy)
                begin
                    state_next = S_IDLE;
                    // header complete: check version and length
                    if (phase_reg == PH_HDR && hdr_cnt_reg == HDR_LAST)
                    begin
                        if (hdr_store[0] != version_reg || hdr_len_w > DEPTH_16)
                        begin
                            status_next  = sfd_pkg::ST_FORMAT;
                            state_next   = S_ONE;
                            phase_next   = PH_SOF1;
                            hdr_cnt_next = '0;
                            pay_cnt_next = '0;
                            rcrc_next    = '0;
                        end
                        else
                        begin
                            pay_cnt_next = '0;
                            phase_next   = (hdr_len_w != '0) ? PH_PAY : PH_CRCL;
                        end
                    end
                end
            end
            S_ONE:
            begin
                // single result without payload data
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_type_next   = hdr_store[1];
                    out_seq_next    = hdr_seq_w;
                    out_len_next    = hdr_len_w;
                    out_data_next   = '0;
                    out_dv_next     = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // one payload byte per result
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = sfd_pkg::ST_GOOD;
                    out_type_next   = hdr_store[1];
                    out_seq_next    = hdr_seq_w;
                    out_len_next    = hdr_len_w;
                    out_data_next   = ram_rdata;
                    out_dv_next     = 1'b1;
                    out_last_next   = (16'(emit_inc) == hdr_len_w);
                    if (16'(emit_inc) == hdr_len_w)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_inc;
                        state_next    = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_SOF1;
            hdr_cnt_reg    <= '0;
            pay_cnt_reg    <= '0;
            emit_idx_reg   <= '0;
            rcrc_reg       <= '0;
            status_reg     <= sfd_pkg::ST_GOOD;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_type_reg   <= '0;
            out_seq_reg    <= '0;
            out_len_reg    <= '0;
            out_data_reg   <= '0;
            out_dv_reg     <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            pay_cnt_reg    <= pay_cnt_next;
            emit_idx_reg   <= emit_idx_next;
            rcrc_reg       <= rcrc_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_type_reg   <= out_type_next;
            out_seq_reg    <= out_seq_next;
            out_len_reg    <= out_len_next;
            out_data_reg   <= out_data_next;
            out_dv_reg     <= out_dv_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.status         = out_status_reg;
    assign res.msg_type       = out_type_reg;
    assign res.seq_number     = out_seq_reg;
    assign res.payload_length = out_len_reg;
    assign res.data_byte      = out_data_reg;
    assign res.data_valid     = out_dv_reg;
    assign res.last           = out_last_reg;

    // checks
    `SFD_ASSERT_IMP(a_ready_crc_idle, clk, rst_n, rx.ready, !crc_busy)
    `SFD_ASSERT_IMP(a_emit_in_range, clk, rst_n, state_reg == S_EMIT, 16'(emit_idx_reg) < hdr_len_w)
    `SFD_ASSERT_IMP(a_no_data_is_last, clk, rst_n, out_valid_reg && !out_dv_reg, out_last_reg)
    `SFD_ASSERT_NXT(a_crc_start_busy, clk, rst_n, crc_cmd.start, state_reg == S_CRC)

endmodule

// File: sim/tb_serial_frame_deframer_crc_check.sv
`timescale 1ns / 1ps

module tb_serial_frame_deframer_crc_check;

    localparam int PAYLOAD_DEPTH = 48;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 60;
    localparam int CFG_SPACING   = 30;
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_LIMIT  = 10;

    // where the deframer stands in the byte stream
    typedef enum logic [2:0] {
        HUNT_ONE,
        HUNT_TWO,
        IN_HEADER,
        IN_PAYLOAD,
        CRC_LOW,
        CRC_HIGH,
        AWAIT_END
    } rx_phase_t;

    typedef struct {
        sfd_pkg::status_t status;
        logic [7:0]       msg_type;
        logic [15:0]      seq_number;
        logic [15:0]      payload_length;
        logic [7:0]       data_byte;
        logic             data_valid;
        logic             last;
    } frame_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    sfd_byte_if   rx ();
    sfd_result_if res ();

    serial_frame_deframer_crc_check #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx),
        .res       (res)
    );

    // marker and version settings as the block should hold them
    logic [7:0] reg_start_one;
    logic [7:0] reg_start_two;
    logic [7:0] reg_version;
    logic [7:0] reg_end;

    // deframer state as predicted
    rx_phase_t  p_phase;
    int         p_hdr_count;
    logic [7:0] p_header [sfd_pkg::HDR_LEN];
    int         p_pay_count;
    logic [7:0] p_payload [PAYLOAD_DEPTH];
    logic [15:0] p_crc;
    logic [15:0] p_rx_crc;

    frame_result_t queued_results [$];

    int fail_count;
    int bytes_sent;
    int hold_req;
    int cycles;
    bit gaps_on;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_serial_frame_deframer_crc_check: done, errors");
        $finish;
    end

    // crc-16/modbus, one byte, lsb first
    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ sfd_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function void predictor_restart();
        p_phase     = HUNT_ONE;
        p_hdr_count = 0;
        p_pay_count = 0;
        p_rx_crc    = 16'h0000;
        p_crc       = sfd_pkg::CRC_INIT;
    endfunction

    function void queue_result(sfd_pkg::status_t st, logic [7:0] d, logic dv, logic lst);
        frame_result_t r;
        r.status         = st;
        r.msg_type       = p_header[1];
        r.seq_number     = {p_header[3], p_header[2]};
        r.payload_length = {p_header[5], p_header[4]};
        r.data_byte      = d;
        r.data_valid     = dv;
        r.last           = lst;
        queued_results.push_back(r);
    endfunction

    // advance the predicted deframer by one accepted byte
    function void deframe_byte(logic [7:0] b);
        logic [15:0] len;
        len = {p_header[5], p_header[4]};
        case (p_phase)
            HUNT_ONE:
            begin
                if (b == reg_start_one)
                    p_phase = HUNT_TWO;
            end
            HUNT_TWO:
            begin
                // second marker is tested first, so equal markers open a frame
                if (b == reg_start_two)
                begin
                    p_phase = IN_HEADER;
                    p_crc   = sfd_pkg::CRC_INIT;
                end
                else if (b == reg_start_one)
                    p_phase = HUNT_TWO;
                else
                    p_phase = HUNT_ONE;
                p_hdr_count = 0;
            end
            IN_HEADER:
            begin
                p_header[p_hdr_count] = b;
                p_hdr_count++;
                p_crc = crc16_next(p_crc, b);
                if (p_hdr_count == sfd_pkg::HDR_LEN)
                begin
                    len = {p_header[5], p_header[4]};
                    if (p_header[0] != reg_version || len > PAYLOAD_DEPTH)
                    begin
                        queue_result(sfd_pkg::ST_FORMAT, 8'h00, 1'b0, 1'b1);
                        predictor_restart();
                    end
                    else
                    begin
                        p_pay_count = 0;
                        p_phase     = (len == 0) ? CRC_LOW : IN_PAYLOAD;
                    end
                end
            end
            IN_PAYLOAD:
            begin
                p_payload[p_pay_count] = b;
                p_pay_count++;
                p_crc = crc16_next(p_crc, b);
                if (p_pay_count >= len)
                    p_phase = CRC_LOW;
            end
            CRC_LOW:
            begin
                p_rx_crc = {8'h00, b};
                p_phase  = CRC_HIGH;
            end
            CRC_HIGH:
            begin
                p_rx_crc[15:8] = b;
                p_phase        = AWAIT_END;
            end
            AWAIT_END:
            begin
                // end byte is judged before the crc
                if (b != reg_end)
                    queue_result(sfd_pkg::ST_NO_END, 8'h00, 1'b0, 1'b1);
                else if (p_crc != p_rx_crc)
                    queue_result(sfd_pkg::ST_CRC_BAD, 8'h00, 1'b0, 1'b1);
                else if (len == 0)
                    queue_result(sfd_pkg::ST_GOOD, 8'h00, 1'b0, 1'b1);
                else
                    for (int i = 0; i < len; i++)
                        queue_result(sfd_pkg::ST_GOOD, p_payload[i], 1'b1, (i + 1 == len));
                predictor_restart();
            end
            default:
                predictor_restart();
        endcase
    endfunction

    // offer one byte, hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            rx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        bytes_sent++;
        deframe_byte(b);
    endtask

    task automatic drive_frame(input logic [7:0] ver, input logic [7:0] kind,
                               input logic [15:0] seq, input logic [15:0] len,
                               input bit bad_crc, input bit bad_end);
        logic [7:0]  body [$];
        logic [15:0] crc;
        int          n;
        n    = (len > PAYLOAD_DEPTH) ? 0 : len;
        body = {ver, kind, seq[7:0], seq[15:8], len[7:0], len[15:8]};
        repeat (n) body.push_back(8'($urandom_range(0, 255)));
        crc = sfd_pkg::CRC_INIT;
        foreach (body[i])
            crc = crc16_next(crc, body[i]);
        if (bad_crc)
            crc = crc ^ 16'(1 << $urandom_range(0, 15));
        send_byte(reg_start_one);
        send_byte(reg_start_two);
        foreach (body[i])
            send_byte(body[i]);
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        send_byte(bad_end ? (reg_end ^ 8'($urandom_range(1, 255))) : reg_end);
    endtask

    task automatic send_good(input logic [15:0] len);
        drive_frame(reg_version, 8'($urandom), 16'($urandom), len, 1'b0, 1'b0);
    endtask

    // bring the parser back to hunting, then let every result drain
    task automatic wait_idle();
        logic [7:0] filler;
        filler = reg_start_one + 8'd1;
        if (filler == reg_start_two)
            filler = filler + 8'd1;
        while (p_phase != HUNT_ONE)
            send_byte(filler);
        rx.valid <= 1'b0;
        while (queued_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input sfd_pkg::cfg_index_t idx, input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            sfd_pkg::CFG_START_ONE: reg_start_one = v;
            sfd_pkg::CFG_START_TWO: reg_start_two = v;
            sfd_pkg::CFG_VERSION:   reg_version   = v;
            sfd_pkg::CFG_END:       reg_end       = v;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [7:0] s1, input logic [7:0] s2,
                               input logic [7:0] ver, input logic [7:0] eb);
        wait_idle();
        write_reg(sfd_pkg::CFG_START_ONE, s1);
        write_reg(sfd_pkg::CFG_START_TWO, s2);
        write_reg(sfd_pkg::CFG_VERSION, ver);
        write_reg(sfd_pkg::CFG_END, eb);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // result sink: random stalls per beat, long hold on request
    initial
    begin : result_sink
        int wait_cycles;
        res.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req > 0)
            begin
                res.ready <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                wait_cycles = gaps_on ? $urandom_range(0, 4) : 0;
                if (wait_cycles > 0)
                begin
                    res.ready <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                end
            end
            res.ready <= 1'b1;
            @(posedge clk);
            while (!res.valid && hold_req == 0)
                @(posedge clk);
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : check_beat
        frame_result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (queued_results.size() == 0)
                note_failure($sformatf(
                    "unexpected result st=%0d type=%02h seq=%04h len=%04h data=%02h dv=%0b last=%0b",
                    res.status, res.msg_type, res.seq_number, res.payload_length,
                    res.data_byte, res.data_valid, res.last));
            else
            begin
                want = queued_results.pop_front();
                if (res.status !== want.status || res.msg_type !== want.msg_type ||
                    res.seq_number !== want.seq_number ||
                    res.payload_length !== want.payload_length ||
                    res.data_byte !== want.data_byte ||
                    res.data_valid !== want.data_valid || res.last !== want.last)
                    note_failure($sformatf({
                        "exp st=%0d type=%02h seq=%04h len=%04h data=%02h dv=%0b last=%0b, ",
                        "got st=%0d type=%02h seq=%04h len=%04h data=%02h dv=%0b last=%0b"},
                        want.status, want.msg_type, want.seq_number, want.payload_length,
                        want.data_byte, want.data_valid, want.last,
                        res.status, res.msg_type, res.seq_number, res.payload_length,
                        res.data_byte, res.data_valid, res.last));
            end
        end
    end

    // good frames at the extremes of length, type and sequence
    task automatic test_good_frames();
        send_good(16'd1);
        send_good(16'd0);
        send_good(16'(PAYLOAD_DEPTH));
        drive_frame(reg_version, 8'h00, 16'h0000, 16'd2, 1'b0, 1'b0);
        drive_frame(reg_version, 8'hFF, 16'hFFFF, 16'd3, 1'b0, 1'b0);
    endtask

    // wrong version and lengths past the buffer
    task automatic test_format_errors();
        drive_frame(reg_version ^ 8'h80, 8'h12, 16'h3456, 16'd2, 1'b0, 1'b0);
        drive_frame(reg_version, 8'h21, 16'h0102, 16'(PAYLOAD_DEPTH + 1), 1'b0, 1'b0);
        drive_frame(reg_version, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        drive_frame(reg_version, 8'h7E, 16'h8000, 16'h0100, 1'b0, 1'b0);
    endtask

    // bad end byte, bad crc, and both at once
    task automatic test_trailer_errors();
        drive_frame(reg_version, 8'h33, 16'h1111, 16'd2, 1'b0, 1'b1);
        drive_frame(reg_version, 8'h44, 16'h2222, 16'd1, 1'b1, 1'b0);
        drive_frame(reg_version, 8'h55, 16'h3333, 16'd0, 1'b1, 1'b1);
        drive_frame(reg_version, 8'h66, 16'h4444, 16'd0, 1'b1, 1'b0);
    endtask

    // repeated first marker, and a first marker followed by noise
    task automatic test_start_hunting();
        send_byte(reg_start_one);
        send_byte(reg_start_one);
        send_good(16'd2);
        send_byte(8'h00);
        send_byte(reg_start_one);
        send_byte(8'h00);
        send_good(16'd1);
    endtask

    // register extremes, equal start markers among them
    task automatic test_register_extremes();
        load_config(8'h00, 8'h00, 8'h00, 8'h00);
        send_byte(8'h00);
        send_good(16'd1);
        send_good(16'd0);
        load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_good(16'd2);
        drive_frame(reg_version, 8'h01, 16'h0203, 16'd1, 1'b0, 1'b1);
        load_config(8'hFF, 8'h00, 8'h80, 8'h7F);
        send_good(16'd3);
        drive_frame(8'h7F, 8'h01, 16'h0203, 16'd1, 1'b0, 1'b0);
        load_config(8'hAA, 8'h55, 8'h01, 8'h0D);
    endtask

    // long result stall so the input backs up, then a drained pause
    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_req = 600;
        send_good(16'(PAYLOAD_DEPTH));
        send_good(16'd5);
        gaps_on = 1'b1;
        wait_idle();
        send_good(16'd4);
    endtask

    // mostly well-formed frames with random content, some broken ones
    task automatic test_random_traffic();
        int start_count;
        int next_cfg;
        int pick;
        logic [7:0] s1;
        start_count = bytes_sent;
        next_cfg    = bytes_sent + CFG_SPACING;
        while (bytes_sent - start_count < RANDOM_BYTES)
        begin
            if (bytes_sent >= next_cfg)
            begin
                s1 = 8'($urandom);
                load_config(s1, ($urandom_range(0, 3) == 0) ? s1 : 8'($urandom),
                            8'($urandom), 8'($urandom));
                next_cfg = bytes_sent + CFG_SPACING;
            end
            if ($urandom_range(0, 9) == 0)
                gaps_on = !gaps_on;
            pick = $urandom_range(0, 99);
            if (pick < 58)
                send_good(16'($urandom_range(0, 6)));
            else if (pick < 64)
                send_good(16'($urandom_range(0, PAYLOAD_DEPTH)));
            else if (pick < 71)
                drive_frame(reg_version, 8'($urandom), 16'($urandom),
                            16'($urandom_range(0, 6)), 1'b1, 1'b0);
            else if (pick < 77)
                drive_frame(reg_version, 8'($urandom), 16'($urandom),
                            16'($urandom_range(0, 6)), 1'($urandom), 1'b1);
            else if (pick < 81)
                drive_frame(reg_version ^ 8'($urandom_range(1, 255)), 8'($urandom),
                            16'($urandom), 16'($urandom_range(0, 6)), 1'b0, 1'b0);
            else if (pick < 85)
                drive_frame(reg_version, 8'($urandom), 16'($urandom),
                            16'($urandom_range(PAYLOAD_DEPTH + 1, 16'hFFFF)), 1'b0, 1'b0);
            else if (pick < 94)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            else
            begin
                // frame cut short, the next one lands mid-frame
                send_byte(reg_start_one);
                send_byte(reg_start_two);
                repeat ($urandom_range(0, 8)) send_byte(8'($urandom));
            end
        end
        gaps_on = 1'b1;
    endtask

    // sequence of tests
    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= sfd_pkg::CFG_START_ONE;
        cfg_data      <= 8'h00;
        rx.valid      <= 1'b0;
        rx.rx_byte    <= 8'h00;
        fail_count    = 0;
        bytes_sent    = 0;
        hold_req      = 0;
        gaps_on       = 1'b1;
        reg_start_one = 8'hAA;
        reg_start_two = 8'h55;
        reg_version   = 8'h01;
        reg_end       = 8'h0D;
        foreach (p_header[i])
            p_header[i] = 8'h00;
        predictor_restart();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_good_frames();
        test_format_errors();
        test_trailer_errors();
        test_start_hunting();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (fail_count == 0)
            $display("tb_serial_frame_deframer_crc_check: done, clean");
        else
            $display("tb_serial_frame_deframer_crc_check: done, errors");
        $finish;
    end

endmodule
